[design/nmt_pkg.sv]
// ----------------------------------------------------------------------------
// nmt_pkg: shared definitions for the named mark table
// Sizes, operation codes, name codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package nmt_pkg;

  localparam int MARK_SLOTS = 32;
  localparam int LINE_BITS  = 32;
  localparam int COL_BITS   = 16;
  localparam int NAME_BITS  = 8;
  localparam int OP_BITS    = 3;

  // slot index and scan counter (the counter also holds MARK_SLOTS itself)
  localparam int IDX_W = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
  localparam int CNT_W = $clog2(MARK_SLOTS + 1);

  localparam logic [OP_BITS-1:0] OP_CLEAR_ALL   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_SET         = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SET_CONTEXT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_GET         = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR_LINE  = 3'd4;

  localparam logic [NAME_BITS-1:0] NAME_NONE     = 8'h00;
  localparam logic [NAME_BITS-1:0] NAME_QUOTE    = 8'h27;
  localparam logic [NAME_BITS-1:0] NAME_BACKTICK = 8'h60;

  typedef logic [IDX_W-1:0] idx_t;

  // entry write (set mark)
  typedef struct packed {
    logic                 en;
    idx_t                 addr;
    logic [NAME_BITS-1:0] name;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  col;
  } wr_req_t;

  // entry free requests
  typedef struct packed {
    logic all;
    logic en;
    idx_t addr;
  } clr_req_t;

  // one entry as read from the store
  typedef struct packed {
    logic                 valid;
    logic [NAME_BITS-1:0] name;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  col;
  } entry_t;

  // verdict of the shared compare unit on one entry
  typedef struct packed {
    logic name_hit;
    logic free;
    logic line_hit;
  } cmp_res_t;

  function automatic logic is_letter(input logic [NAME_BITS-1:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

[design/named_mark_table.sv]
// ----------------------------------------------------------------------------
// named_mark_table: fully associative table of named marks
// Set, get and clear marks by name; one previous-context mark on the side.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_ready   | operation, mark_name, line_ref, column
//  out     | out_valid / out_ready | success, found_line, found_column
//
//  Set of a letter, get of a table name and clear by line scan every slot
//  through one store read port and one compare unit before the result is
//  loaded; other operations skip the scan.
//  One item at a time; in_ready is high only while the sequencer is idle.
//  A result waits in the output register; a new item may be accepted then,
//  and its own result is held back until the old one is taken.
//  Reset is synchronous; it frees every slot and drops the context mark.
//
module named_mark_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nmt_pkg::OP_BITS-1:0]   operation,
  input  logic [nmt_pkg::NAME_BITS-1:0] mark_name,
  input  logic [nmt_pkg::LINE_BITS-1:0] line_ref,
  input  logic [nmt_pkg::COL_BITS-1:0]  column,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          success,
  output logic [nmt_pkg::LINE_BITS-1:0] found_line,
  output logic [nmt_pkg::COL_BITS-1:0]  found_column
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t state;

  // held item
  logic [nmt_pkg::OP_BITS-1:0]   op_q;
  logic [nmt_pkg::NAME_BITS-1:0] name_q;
  logic [nmt_pkg::LINE_BITS-1:0] line_q;
  logic [nmt_pkg::COL_BITS-1:0]  col_q;

  // scan bookkeeping
  logic [nmt_pkg::CNT_W-1:0] iss_cnt;   // next slot to read
  logic                      cmp_pend;  // read data in rd is live
  nmt_pkg::idx_t             cmp_idx;   // slot that rd holds
  logic                      hit_found;
  nmt_pkg::idx_t             hit_idx;
  logic                      free_found;
  nmt_pkg::idx_t             free_idx;

  // context mark
  logic                          ctx_valid;
  logic [nmt_pkg::LINE_BITS-1:0] ctx_line;
  logic [nmt_pkg::COL_BITS-1:0]  ctx_col;

  // pending result
  logic                          res_ok;
  logic [nmt_pkg::LINE_BITS-1:0] res_line;
  logic [nmt_pkg::COL_BITS-1:0]  res_col;

  nmt_pkg::idx_t     rd_addr;
  nmt_pkg::wr_req_t  wr;
  nmt_pkg::clr_req_t clr;
  nmt_pkg::entry_t   rd;
  nmt_pkg::cmp_res_t cmp;

  logic accept;
  logic issue;
  logic last_cmp;
  logic cur_hit;
  logic cur_free;
  logic set_ok;
  logic out_free;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign issue    = (state == SCAN) && (iss_cnt < nmt_pkg::CNT_W'(nmt_pkg::MARK_SLOTS));
  assign rd_addr  = iss_cnt[nmt_pkg::IDX_W-1:0];
  assign last_cmp = cmp_pend && (cmp_idx == nmt_pkg::IDX_W'(nmt_pkg::MARK_SLOTS - 1));

  // compare verdicts only count while the read data is live
  assign cur_hit  = cmp_pend && cmp.name_hit;
  assign cur_free = cmp_pend && cmp.free;
  assign set_ok   = hit_found || cur_hit || free_found || cur_free;

  // clear all acts at accept; clear by line frees each matching slot in turn
  assign clr.all  = accept && (operation == nmt_pkg::OP_CLEAR_ALL);
  assign clr.en   = cmp_pend && (op_q == nmt_pkg::OP_CLEAR_LINE) && cmp.line_hit;
  assign clr.addr = cmp_idx;

  // set commits on the last compare: matching name first, else lowest free
  always_comb begin
    wr.en   = last_cmp && (op_q == nmt_pkg::OP_SET) && set_ok;
    wr.name = name_q;
    wr.line = line_q;
    wr.col  = col_q;
    priority if (hit_found) begin
      wr.addr = hit_idx;
    end else if (cur_hit) begin
      wr.addr = cmp_idx;
    end else if (free_found) begin
      wr.addr = free_idx;
    end else begin
      wr.addr = cmp_idx;
    end
  end

  nmt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .clr     (clr),
    .rd      (rd)
  );

  nmt_cmp u_cmp (
    .entry    (rd),
    .key_name (name_q),
    .key_line (line_q),
    .res      (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ctx_valid <= 1'b0;
      out_valid <= 1'b0;
      cmp_pend  <= 1'b0;
      iss_cnt   <= '0;
    end else begin
      // FINISH reloads the output register itself when it is taken
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            op_q       <= operation;
            name_q     <= mark_name;
            line_q     <= line_ref;
            col_q      <= column;
            iss_cnt    <= '0;
            cmp_pend   <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            res_ok     <= 1'b0;
            res_line   <= '0;
            res_col    <= '0;
            state      <= FINISH;
            unique case (operation)
              nmt_pkg::OP_CLEAR_ALL: begin
                ctx_valid <= 1'b0;
              end
              nmt_pkg::OP_SET: begin
                // a name that is no letter fails without a scan
                if (nmt_pkg::is_letter(mark_name)) begin
                  state <= SCAN;
                end
              end
              nmt_pkg::OP_SET_CONTEXT: begin
                ctx_valid <= 1'b1;
                ctx_line  <= line_ref;
                ctx_col   <= column;
                res_ok    <= 1'b1;
              end
              nmt_pkg::OP_GET: begin
                if (mark_name == nmt_pkg::NAME_QUOTE ||
                    mark_name == nmt_pkg::NAME_BACKTICK) begin
                  if (ctx_valid) begin
                    res_ok   <= 1'b1;
                    res_line <= ctx_line;
                    res_col  <= ctx_col;
                  end
                end else if (mark_name != nmt_pkg::NAME_NONE) begin
                  state <= SCAN;
                end
              end
              nmt_pkg::OP_CLEAR_LINE: begin
                if (ctx_valid && ctx_line == line_ref) begin
                  ctx_valid <= 1'b0;
                end
                state <= SCAN;
              end
              default: begin
                // unused codes: table and context mark unchanged, zero result
              end
            endcase
          end
        end

        SCAN: begin
          cmp_pend <= issue;
          if (issue) begin
            iss_cnt <= iss_cnt + 1'b1;
            cmp_idx <= rd_addr;
          end
          if (cur_hit && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
            if (op_q == nmt_pkg::OP_GET) begin
              res_ok   <= 1'b1;
              res_line <= rd.line;
              res_col  <= rd.col;
            end
          end
          if (cur_free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (last_cmp) begin
            if (op_q == nmt_pkg::OP_SET) begin
              res_ok <= set_ok;
            end
            state <= FINISH;
          end
        end

        FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            success      <= res_ok;
            found_line   <= res_line;
            found_column <= res_col;
            state        <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an accepted item leaves in_ready low in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("in_ready high right after accept");

  // a failed result carries zero position
  a_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (found_line == '0 && found_column == '0))
    else $error("nonzero position on a miss");

  // entries are written only at the end of a set scan
  a_write_in_set_scan: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == SCAN && op_q == nmt_pkg::OP_SET && last_cmp))
    else $error("entry write outside a set scan");

  // scan counter never runs past the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    iss_cnt <= nmt_pkg::CNT_W'(nmt_pkg::MARK_SLOTS))
    else $error("scan counter past table end");

  // a slot is freed by line only for a clear-by-line item
  a_clear_only_line_op: assert property (@(posedge clk) disable iff (rst)
    clr.en |-> (op_q == nmt_pkg::OP_CLEAR_LINE && state == SCAN))
    else $error("slot cleared outside clear by line");
`endif

endmodule

[design/nmt_store.sv]
// ----------------------------------------------------------------------------
// nmt_store: mark entry storage
// Name, line and column memories with one registered read port and one write
// port; per-slot occupied bits in flops so clear all frees every slot at once.
// ----------------------------------------------------------------------------
module nmt_store (
  input  logic              clk,
  input  logic              rst,
  input  nmt_pkg::idx_t     rd_addr,
  input  nmt_pkg::wr_req_t  wr,
  input  nmt_pkg::clr_req_t clr,
  output nmt_pkg::entry_t   rd
);

  logic [nmt_pkg::MARK_SLOTS-1:0] valid;
  logic [nmt_pkg::NAME_BITS-1:0]  names [nmt_pkg::MARK_SLOTS];
  logic [nmt_pkg::LINE_BITS-1:0]  lines [nmt_pkg::MARK_SLOTS];
  logic [nmt_pkg::COL_BITS-1:0]   cols  [nmt_pkg::MARK_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clr.all) begin
      valid <= '0;
    end else begin
      if (clr.en) begin
        valid[clr.addr] <= 1'b0;
      end
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      names[wr.addr] <= wr.name;
      lines[wr.addr] <= wr.line;
      cols[wr.addr]  <= wr.col;
    end
    rd.valid <= valid[rd_addr];
    rd.name  <= names[rd_addr];
    rd.line  <= lines[rd_addr];
    rd.col   <= cols[rd_addr];
  end

endmodule

[design/nmt_cmp.sv]
// ----------------------------------------------------------------------------
// nmt_cmp: shared entry compare unit
// Checks one stored entry against the key name and key line.
// ----------------------------------------------------------------------------
module nmt_cmp (
  input  nmt_pkg::entry_t               entry,
  input  logic [nmt_pkg::NAME_BITS-1:0] key_name,
  input  logic [nmt_pkg::LINE_BITS-1:0] key_line,
  output nmt_pkg::cmp_res_t             res
);

  // free slots never match, whatever they hold
  assign res.name_hit = entry.valid && (entry.name == key_name);
  assign res.free     = !entry.valid;
  assign res.line_hit = entry.valid && (entry.line == key_line);

endmodule
